// ----- sv/keypad_debounce_long_repeat_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the keypad debounce block
// Implication checks, each written once and switched off by ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef KEYPAD_DEBOUNCE_LONG_REPEAT_ASSERT_SVH
`define KEYPAD_DEBOUNCE_LONG_REPEAT_ASSERT_SVH

`ifndef ASSERT_OFF

// Same-cycle implication.
`define KDLR_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication.
`define KDLR_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define KDLR_ASSERT_IMP(label, clk, rst, ante, cons)
`define KDLR_ASSERT_NXT(label, clk, rst, ante, cons)

`endif

`endif

// ----- sv/kdlr_pkg.sv -----
// ----------------------------------------------------------------------------
// kdlr_pkg
// Types and constants shared by the keypad debounce block.
// ----------------------------------------------------------------------------
`default_nettype none

package kdlr_pkg;

   localparam int TIME_W    = 32;
   localparam int MS_W      = 16;
   localparam int PIN_COUNT = 4;
   localparam int KEY_IDX_W = 4;
   localparam int CSR_IDX_W = 2;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_DEBOUNCE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LONG_PRESS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_REPEAT     = 2'd2;

   localparam logic [MS_W-1:0] DEBOUNCE_RESET   = 16'd50;
   localparam logic [MS_W-1:0] LONG_PRESS_RESET = 16'd1000;
   localparam logic [MS_W-1:0] REPEAT_RESET     = 16'd200;

   // Event kinds.
   localparam logic [1:0] KIND_SHORT  = 2'd0;
   localparam logic [1:0] KIND_LONG   = 2'd1;
   localparam logic [1:0] KIND_REPEAT = 2'd2;

   typedef struct packed {
      logic [MS_W-1:0] debounce_ms;
      logic [MS_W-1:0] long_press_ms;
      logic [MS_W-1:0] repeat_ms;
   } kdlr_cfg_type;

   typedef struct packed {
      logic                 event_valid;
      logic [1:0]           event_key;
      logic [1:0]           event_kind;
      logic [PIN_COUNT-1:0] pressed_mask;
   } kdlr_result_type;

endpackage

`default_nettype wire

// ----- sv/keypad_debounce_long_repeat.sv -----
// ----------------------------------------------------------------------------
// keypad_debounce_long_repeat
// Debounced keypad scanner with short press, long press and auto-repeat.
// ----------------------------------------------------------------------------
// Each poll item carries a millisecond timestamp and the active-low pin
// levels of four keys and yields exactly one result item: the first key
// event found, scanning from key 0 upward, and the debounced pressed mask.
// Keys are visited by a sequencer that runs the debounce check of each key
// and then the long-press or repeat check of a key that is held, both
// through one shared 32-bit elapsed-time comparator. The scan ends early at
// the first event, and req_stall stays high until its result is loaded
// into the output register, so a new poll is not taken before the last
// poll has been scanned to its end or its first event. A finished
// result waits in an output register, so the next poll can be taken while it
// is still stalled; that poll then holds until the register frees. The
// configuration registers are written through the csr port, which is always
// ready, and should be written only while no poll is open.
`default_nettype none

module keypad_debounce_long_repeat #(
   parameter int NUM_KEYS = 4
) (
   input  wire logic                               clock,
   input  wire logic                               reset,

   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic [kdlr_pkg::TIME_W-1:0]        req_now_ms,
   input  wire logic [kdlr_pkg::PIN_COUNT-1:0]     req_pin_levels,

   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic                                    rsp_event_valid,
   output logic [1:0]                              rsp_event_key,
   output logic [1:0]                              rsp_event_kind,
   output logic [kdlr_pkg::PIN_COUNT-1:0]          rsp_pressed_mask,

   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [kdlr_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [kdlr_pkg::MS_W-1:0]          csr_data
);
   import kdlr_pkg::*;

`include "keypad_debounce_long_repeat_assert.svh"

   kdlr_cfg_type    cfg_ff, cfg_in;
   kdlr_result_type res_ff;
   kdlr_result_type result;
   logic            rsp_valid_ff, rsp_valid_in;
   logic            busy;
   logic            done;
   logic            out_free;
   logic            start;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_DEBOUNCE:   cfg_in.debounce_ms   = csr_data;
            CSR_LONG_PRESS: cfg_in.long_press_ms = csr_data;
            CSR_REPEAT:     cfg_in.repeat_ms     = csr_data;
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   assign start     = req_valid && !busy;
   assign req_stall = busy;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   kdlr_ctrl #(
      .NUM_KEYS (NUM_KEYS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .now_ms     (req_now_ms),
      .pin_levels (req_pin_levels),
      .cfg        (cfg_ff),
      .out_free   (out_free),
      .busy       (busy),
      .done       (done),
      .result     (result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (done) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff      <= 1'b0;
         cfg_ff.debounce_ms   <= DEBOUNCE_RESET;
         cfg_ff.long_press_ms <= LONG_PRESS_RESET;
         cfg_ff.repeat_ms     <= REPEAT_RESET;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         cfg_ff       <= cfg_in;
      end
   end

   always_ff @(posedge clock) begin
      if (done) begin
         res_ff <= result;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_event_valid  = res_ff.event_valid;
   assign rsp_event_key    = res_ff.event_key;
   assign rsp_event_kind   = res_ff.event_kind;
   assign rsp_pressed_mask = res_ff.pressed_mask;

   // A poll keeps the input side closed while the keys are scanned.
   `KDLR_ASSERT_NXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall)

   // A finished scan always lands in the output register.
   `KDLR_ASSERT_NXT(a_done_loads_output, clock, reset, done, rsp_valid)

   // A result without an event reports key and kind as zero.
   `KDLR_ASSERT_IMP(a_no_event_zero, clock, reset,
                    rsp_valid && !rsp_event_valid,
                    rsp_event_key == 2'd0 && rsp_event_kind == KIND_SHORT)

endmodule

`default_nettype wire

// ----- sv/kdlr_elapsed.sv -----
// ----------------------------------------------------------------------------
// kdlr_elapsed
// Shared timer unit: wrapping elapsed time compared against a limit.
// ----------------------------------------------------------------------------
`default_nettype none

module kdlr_elapsed (
   input  wire logic [kdlr_pkg::TIME_W-1:0] now,
   input  wire logic [kdlr_pkg::TIME_W-1:0] since,
   input  wire logic [kdlr_pkg::MS_W-1:0]   limit,
   output logic                             reached
);
   import kdlr_pkg::*;

   logic [TIME_W-1:0] elapsed;

   // The subtraction wraps modulo 2^32, so a timestamp rollover is harmless.
   assign elapsed = now - since;
   assign reached = elapsed >= {{(TIME_W-MS_W){1'b0}}, limit};

endmodule

`default_nettype wire

// ----- sv/kdlr_ctrl.sv -----
// ----------------------------------------------------------------------------
// kdlr_ctrl
// Per-key state and the sequencer that visits the keys in turn, a debounce
// step per key and a hold step per held key, through one shared timer unit.
// ----------------------------------------------------------------------------
`default_nettype none

module kdlr_ctrl #(
   parameter int NUM_KEYS = 4
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   input  wire logic [kdlr_pkg::TIME_W-1:0]        now_ms,
   input  wire logic [kdlr_pkg::PIN_COUNT-1:0]     pin_levels,
   input  wire kdlr_pkg::kdlr_cfg_type             cfg,
   input  wire logic                               out_free,
   output logic                                    busy,
   output logic                                    done,
   output kdlr_pkg::kdlr_result_type               result
);
   import kdlr_pkg::*;

   localparam int KEY_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_DEB    = 2'd1;
   localparam logic [1:0] ST_HOLD   = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   logic [1:0]       state_ff, state_in;
   logic [KEY_W-1:0] key_ff, key_in;
   logic             evt_ff, evt_in;
   logic [1:0]       kind_ff, kind_in;

   logic [TIME_W-1:0]    now_ff, now_in;
   logic [PIN_COUNT-1:0] pins_ff, pins_in;

   logic [NUM_KEYS-1:0] raw_ff, raw_in;
   logic [NUM_KEYS-1:0] stable_ff, stable_in;
   logic [NUM_KEYS-1:0] long_ff, long_in;
   logic [TIME_W-1:0]   change_ff [NUM_KEYS];
   logic [TIME_W-1:0]   change_in [NUM_KEYS];
   logic [TIME_W-1:0]   press_ff  [NUM_KEYS];
   logic [TIME_W-1:0]   press_in  [NUM_KEYS];
   logic [TIME_W-1:0]   rep_ff    [NUM_KEYS];
   logic [TIME_W-1:0]   rep_in    [NUM_KEYS];

   logic [KEY_IDX_W-1:0] key4;
   logic                 level;
   logic                 changed;
   logic                 last_key;
   logic [TIME_W-1:0]    since;
   logic [MS_W-1:0]      limit;
   logic                 reached;
   logic                 go_next;

   assign key4     = KEY_IDX_W'(key_ff);
   // Keys without a pin read as released.
   assign level    = (key4 < KEY_IDX_W'(PIN_COUNT)) ? ~pins_ff[key4[1:0]] : 1'b0;
   assign changed  = level != raw_ff[key_ff];
   assign last_key = key_ff == KEY_W'(NUM_KEYS - 1);

   // Operand selection for the shared timer unit.
   always_comb begin
      since = now_ff;
      limit = cfg.debounce_ms;
      case (state_ff)
         ST_DEB: begin
            since = changed ? now_ff : change_ff[key_ff];
            limit = cfg.debounce_ms;
         end
         ST_HOLD: begin
            if (long_ff[key_ff]) begin
               since = rep_ff[key_ff];
               limit = cfg.repeat_ms;
            end else begin
               since = press_ff[key_ff];
               limit = cfg.long_press_ms;
            end
         end
         default: begin
            since = now_ff;
            limit = cfg.debounce_ms;
         end
      endcase
   end

   kdlr_elapsed u_elapsed (
      .now     (now_ff),
      .since   (since),
      .limit   (limit),
      .reached (reached)
   );

   always_comb begin
      state_in  = state_ff;
      key_in    = key_ff;
      evt_in    = evt_ff;
      kind_in   = kind_ff;
      now_in    = now_ff;
      pins_in   = pins_ff;
      raw_in    = raw_ff;
      stable_in = stable_ff;
      long_in   = long_ff;
      change_in = change_ff;
      press_in  = press_ff;
      rep_in    = rep_ff;
      go_next   = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               now_in   = now_ms;
               pins_in  = pin_levels;
               key_in   = '0;
               evt_in   = 1'b0;
               kind_in  = KIND_SHORT;
               state_in = ST_DEB;
            end
         end
         ST_DEB: begin
            raw_in[key_ff] = level;
            if (changed) begin
               change_in[key_ff] = now_ff;
            end
            if (level != stable_ff[key_ff] && reached) begin
               stable_in[key_ff] = level;
               if (level) begin
                  press_in[key_ff] = now_ff;
                  long_in[key_ff]  = 1'b0;
                  state_in         = ST_HOLD;
               end else if (!long_ff[key_ff]) begin
                  evt_in   = 1'b1;
                  kind_in  = KIND_SHORT;
                  state_in = ST_FINISH;
               end else begin
                  // A release after a long press is silent.
                  go_next = 1'b1;
               end
            end else if (stable_ff[key_ff]) begin
               state_in = ST_HOLD;
            end else begin
               go_next = 1'b1;
            end
         end
         ST_HOLD: begin
            if (reached) begin
               rep_in[key_ff] = now_ff;
               evt_in         = 1'b1;
               kind_in        = long_ff[key_ff] ? KIND_REPEAT : KIND_LONG;
               long_in[key_ff] = 1'b1;
               state_in       = ST_FINISH;
            end else begin
               go_next = 1'b1;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (go_next) begin
         if (last_key) begin
            state_in = ST_FINISH;
         end else begin
            key_in   = key_ff + KEY_W'(1);
            state_in = ST_DEB;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         key_ff    <= '0;
         evt_ff    <= 1'b0;
         kind_ff   <= KIND_SHORT;
         raw_ff    <= '0;
         stable_ff <= '0;
         long_ff   <= '0;
         for (int i = 0; i < NUM_KEYS; i++) begin
            change_ff[i] <= '0;
            press_ff[i]  <= '0;
            rep_ff[i]    <= '0;
         end
      end else begin
         state_ff  <= state_in;
         key_ff    <= key_in;
         evt_ff    <= evt_in;
         kind_ff   <= kind_in;
         raw_ff    <= raw_in;
         stable_ff <= stable_in;
         long_ff   <= long_in;
         change_ff <= change_in;
         press_ff  <= press_in;
         rep_ff    <= rep_in;
      end
   end

   always_ff @(posedge clock) begin
      now_ff  <= now_in;
      pins_ff <= pins_in;
   end

   // Only keys that have a pin show in the mask.
   for (genvar j = 0; j < PIN_COUNT; j++) begin : g_mask
      if (j < NUM_KEYS) begin : g_key
         assign result.pressed_mask[j] = stable_ff[j];
      end else begin : g_none
         assign result.pressed_mask[j] = 1'b0;
      end
   end

   assign result.event_valid = evt_ff;
   assign result.event_key   = evt_ff ? key4[1:0] : 2'd0;
   assign result.event_kind  = evt_ff ? kind_ff : KIND_SHORT;

   assign busy = state_ff != ST_IDLE;
   assign done = (state_ff == ST_FINISH) && out_free;

endmodule

`default_nettype wire

// ----- dv/keypad_debounce_long_repeat_tb.sv -----
// ----------------------------------------------------------------------------
// keypad_debounce_long_repeat_tb
// Self-checking testbench for the debounced keypad scanner.
// ----------------------------------------------------------------------------
// Poll items go through the request channel, and each one updates a
// behavioral copy of the per-key debounce, long-press and repeat state. The
// result item that this copy predicts is queued. Every result that leaves
// the block is compared with the oldest prediction. Directed polls cover the
// reset timing, zero and maximum intervals, key priority and time wrap.
// Random polls follow held keys with contact bounce under several
// flow-control mixes. One stretch holds the output off long enough to fill
// the block and stall its input.
// ----------------------------------------------------------------------------
`default_nettype none

module keypad_debounce_long_repeat_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import kdlr_pkg::*;

   localparam int KEYS = 4;
   localparam int CYCLE_LIMIT = 400000;
   localparam int BLOCK_POLLS = 115;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;

   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [TIME_W-1:0]      req_now_ms = '0;
   logic [PIN_COUNT-1:0]   req_pin_levels = '1;

   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic                   rsp_event_valid;
   logic [1:0]             rsp_event_key;
   logic [1:0]             rsp_event_kind;
   logic [PIN_COUNT-1:0]   rsp_pressed_mask;

   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_IDX_W-1:0]   csr_index = '0;
   logic [MS_W-1:0]        csr_data = '0;

   // Flow-control mix in percent per cycle, and the remaining long hold-off.
   int unsigned send_idle_pct = 0;
   int unsigned recv_stall_pct = 0;
   int unsigned hold_off_left = 0;

   int unsigned cycle_count = 0;
   int unsigned mismatch_count = 0;

   kdlr_result_type poll_results_due[$];

   // Behavioral copy of the timing registers and the per-key state.
   logic [MS_W-1:0]   cfg_debounce;
   logic [MS_W-1:0]   cfg_long_press;
   logic [MS_W-1:0]   cfg_repeat;
   logic              key_raw [KEYS];
   logic              key_stable [KEYS];
   logic              key_long [KEYS];
   logic [TIME_W-1:0] key_change_ms [KEYS];
   logic [TIME_W-1:0] key_press_ms [KEYS];
   logic [TIME_W-1:0] key_repeat_ms [KEYS];

   // State of the random key stimulus.
   logic [TIME_W-1:0]    poll_ms;
   logic [PIN_COUNT-1:0] held_keys;

   keypad_debounce_long_repeat #(
      .NUM_KEYS(KEYS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_now_ms(req_now_ms),
      .req_pin_levels(req_pin_levels),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_event_valid(rsp_event_valid),
      .rsp_event_key(rsp_event_key),
      .rsp_event_kind(rsp_event_kind),
      .rsp_pressed_mask(rsp_pressed_mask),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // The long hold-off runs down here, apart from the random stalls.
   always @(posedge clock) begin
      if (hold_off_left != 0) begin
         hold_off_left <= hold_off_left - 1;
      end
   end

   always @(posedge clock) begin
      rsp_stall <= (hold_off_left != 0) || ($urandom_range(99) < recv_stall_pct);
   end

   always @(posedge clock) begin
      kdlr_result_type seen;
      kdlr_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         seen = {rsp_event_valid, rsp_event_key, rsp_event_kind, rsp_pressed_mask};
         if (poll_results_due.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
               $display({"result item with no poll outstanding: ",
                         "valid=%0b key=%0d kind=%0d mask=%b"},
                        seen.event_valid, seen.event_key, seen.event_kind, seen.pressed_mask);
            end
         end else begin
            want = poll_results_due.pop_front();
            if (seen.event_valid !== want.event_valid || seen.event_key !== want.event_key ||
                seen.event_kind !== want.event_kind || seen.pressed_mask !== want.pressed_mask)
            begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display({"poll result mismatch: ",
                            "expected valid=%0b key=%0d kind=%0d mask=%b, ",
                            "got valid=%0b key=%0d kind=%0d mask=%b"},
                           want.event_valid, want.event_key, want.event_kind,
                           want.pressed_mask,
                           seen.event_valid, seen.event_key, seen.event_kind,
                           seen.pressed_mask);
               end
            end
         end
      end
   end

   task automatic clear_key_state();
      cfg_debounce = DEBOUNCE_RESET;
      cfg_long_press = LONG_PRESS_RESET;
      cfg_repeat = REPEAT_RESET;
      for (int k = 0; k < KEYS; k++) begin
         key_raw[k] = 1'b0;
         key_stable[k] = 1'b0;
         key_long[k] = 1'b0;
         key_change_ms[k] = '0;
         key_press_ms[k] = '0;
         key_repeat_ms[k] = '0;
      end
   endtask

   // Scans the keys from index 0 and stops at the first event, so keys after
   // it keep their old state for this poll.
   function automatic kdlr_result_type predict_poll(input logic [TIME_W-1:0] now,
                                                    input logic [PIN_COUNT-1:0] pins);
      kdlr_result_type res;
      logic level;
      logic hit;
      logic [TIME_W-1:0] elapsed;
      res = '0;
      hit = 1'b0;
      for (int k = 0; k < KEYS; k++) begin
         if (!hit) begin
            level = ~pins[k];
            if (level != key_raw[k]) begin
               key_raw[k] = level;
               key_change_ms[k] = now;
            end
            elapsed = now - key_change_ms[k];
            if (level != key_stable[k] && elapsed >= cfg_debounce) begin
               key_stable[k] = level;
               if (level) begin
                  key_press_ms[k] = now;
                  key_long[k] = 1'b0;
               end else if (!key_long[k]) begin
                  hit = 1'b1;
                  res.event_kind = KIND_SHORT;
               end
            end
            if (!hit && key_stable[k]) begin
               if (!key_long[k]) begin
                  elapsed = now - key_press_ms[k];
                  if (elapsed >= cfg_long_press) begin
                     key_long[k] = 1'b1;
                     key_repeat_ms[k] = now;
                     hit = 1'b1;
                     res.event_kind = KIND_LONG;
                  end
               end else begin
                  elapsed = now - key_repeat_ms[k];
                  if (elapsed >= cfg_repeat) begin
                     key_repeat_ms[k] = now;
                     hit = 1'b1;
                     res.event_kind = KIND_REPEAT;
                  end
               end
            end
            if (hit) begin
               res.event_key = k[1:0];
            end
         end
      end
      res.event_valid = hit;
      for (int k = 0; k < PIN_COUNT; k++) begin
         res.pressed_mask[k] = key_stable[k];
      end
      return res;
   endfunction

   // Valid stays high from one item to the next unless the sender idles.
   task automatic send_poll(input logic [TIME_W-1:0] now, input logic [PIN_COUNT-1:0] pins);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_now_ms <= now;
      req_pin_levels <= pins;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      poll_results_due.push_back(predict_poll(now, pins));
   endtask

   task automatic drain_polls();
      req_valid <= 1'b0;
      while (poll_results_due.size() != 0) @(posedge clock);
   endtask

   // Leaves csr_valid high so that writes can follow back to back.
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [MS_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_DEBOUNCE: begin
            cfg_debounce = value;
         end
         CSR_LONG_PRESS: begin
            cfg_long_press = value;
         end
         CSR_REPEAT: begin
            cfg_repeat = value;
         end
         default: begin
         end
      endcase
   endtask

   task automatic set_timing(input logic [MS_W-1:0] debounce, input logic [MS_W-1:0] long_press,
                             input logic [MS_W-1:0] repeat_gap);
      write_csr(CSR_DEBOUNCE, debounce);
      write_csr(CSR_LONG_PRESS, long_press);
      write_csr(CSR_REPEAT, repeat_gap);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [MS_W-1:0] pick_interval();
      int unsigned r = $urandom_range(99);
      if (r < 15) return '0;
      if (r < 20) return '1;
      if (r < 30) return MS_W'($urandom_range(65535));
      return MS_W'($urandom_range(1, 60));
   endfunction

   task automatic test_default_timing();
      send_idle_pct = 0;
      recv_stall_pct = 0;
      send_poll(0, 4'hF);
      send_poll(10, 4'hE);
      send_poll(59, 4'hE);
      send_poll(60, 4'hE);
      send_poll(1059, 4'hE);
      send_poll(1060, 4'hE);
      send_poll(1260, 4'hE);
      // A release after the long event stays silent.
      send_poll(1300, 4'hF);
      send_poll(1350, 4'hF);
      send_poll(2000, 4'hD);
      send_poll(2050, 4'hD);
      send_poll(2100, 4'hF);
      send_poll(2150, 4'hF);
   endtask

   task automatic test_zero_intervals();
      drain_polls();
      set_timing('0, '0, '0);
      // Key 0 wins the scan, so the other pressed keys are not seen yet.
      send_poll(100, 4'h0);
      send_poll(101, 4'hE);
      send_poll(102, 4'h1);
      send_poll(103, 4'hF);
      send_poll(32'hFFFF_FFFF, 4'h7);
      send_poll(0, 4'h7);
   endtask

   task automatic test_extreme_intervals();
      logic [TIME_W-1:0] t0;
      t0 = 32'hFFFF_FFF0;
      drain_polls();
      set_timing('1, '1, '1);
      send_poll(t0, 4'h7);
      send_poll(t0 + 32'd65534, 4'h7);
      send_poll(t0 + 32'd65535, 4'h7);
      send_poll(t0 + 32'd131070, 4'h7);
      send_poll(t0 + 32'd196605, 4'h7);
      send_poll(t0 + 32'd196606, 4'hF);
   endtask

   // Held keys change now and then; single-poll flips model contact bounce.
   task automatic test_random_polls(input int unsigned idle_pct, input int unsigned stall_pct,
                                    input int unsigned blocks);
      int unsigned r;
      logic [TIME_W-1:0] step;
      logic [PIN_COUNT-1:0] pins;
      send_idle_pct = idle_pct;
      recv_stall_pct = stall_pct;
      poll_ms = $urandom;
      held_keys = '0;
      for (int b = 0; b < blocks; b++) begin
         drain_polls();
         if ($urandom_range(3) == 0) begin
            write_csr(CSR_UNUSED, MS_W'($urandom_range(65535)));
         end
         set_timing(pick_interval(), pick_interval(), pick_interval());
         for (int n = 0; n < BLOCK_POLLS; n++) begin
            r = $urandom_range(99);
            if (r < 5) step = '0;
            else if (r < 85) step = $urandom_range(1, 20);
            else if (r < 97) step = $urandom_range(21, 200);
            else if (r < 99) step = $urandom_range(60000, 70000);
            else step = $urandom;
            poll_ms = poll_ms + step;
            r = $urandom_range(99);
            if (r < 10) held_keys = held_keys ^ (4'b1 << $urandom_range(3));
            else if (r < 12) held_keys = PIN_COUNT'($urandom_range(15));
            pins = ~held_keys;
            r = $urandom_range(99);
            if (r < 8) pins = pins ^ (4'b1 << $urandom_range(3));
            else if (r < 11) pins = PIN_COUNT'($urandom_range(15));
            send_poll(poll_ms, pins);
         end
      end
   endtask

   // The output is held off while polls keep coming, so the block fills up.
   task automatic test_output_backpressure();
      drain_polls();
      set_timing(16'd4, 16'd30, 16'd8);
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_off_left <= 300;
      for (int n = 0; n < 30; n++) begin
         poll_ms = poll_ms + 5;
         send_poll(poll_ms, PIN_COUNT'($urandom_range(15)));
      end
   endtask

   initial begin
      clear_key_state();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_default_timing();
      test_zero_intervals();
      test_extreme_intervals();
      test_random_polls(0, 0, 4);
      test_random_polls(63, 0, 4);
      test_random_polls(0, 63, 4);
      test_random_polls(22, 22, 4);
      test_output_backpressure();
      drain_polls();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && poll_results_due.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
